FILE: design/sps_pkg.sv
// Package for the stepper phase sequencer: field widths, register indexes,
// the coil pattern table and the step scaling constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int ANGLE_W         = 16;
  localparam int MAG_W           = ANGLE_W + 1;
  localparam int SPR_W           = 14;
  localparam int DELAY_W         = 10;
  localparam int COIL_W          = 4;
  localparam int PHASE_W         = 3;
  localparam int STEPS_W         = 17;
  localparam int CFG_DATA_W      = 14;

  localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};
  localparam int SPECIAL_ANGLE = 400 << ANGLE_FRAC_BITS;

  // The divisor 360 << ANGLE_FRAC_BITS is 45 << (3 + ANGLE_FRAC_BITS).
  localparam int PROD_W   = MAG_W + SPR_W;
  localparam int DIV_SH   = 3 + ANGLE_FRAC_BITS;
  localparam int X_W      = PROD_W - DIV_SH;
  localparam int RECIP_SH = 30;
  localparam int RECIP_W  = 25;
  localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd44) / 64'd45);
  localparam int QPROD_W  = X_W + RECIP_W;
  localparam int QUOT_W   = QPROD_W - RECIP_SH;

  localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(2048);
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(10);

  typedef enum logic [1:0] {
    REG_HALF_STEP_MODE = 2'd0,
    REG_STEPS_PER_REV  = 2'd1,
    REG_STEP_DELAY     = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } op_t;

  localparam logic [COIL_W-1:0] HALF_TABLE [8] = '{
    4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
  };

  function automatic logic [COIL_W-1:0] pattern_at(logic [PHASE_W-1:0] p, logic rev,
                                                   logic half);
    logic [PHASE_W-1:0] k;
    k = half ? p : {1'b0, p[1:0]};
    if (rev) begin
      k = half ? ~k : {1'b0, ~k[1:0]};
    end
    if (!half) begin
      k = {k[1:0], 1'b0};
    end
    return HALF_TABLE[k];
  endfunction

endpackage

`default_nettype wire

FILE: design/sps_cmd_if.sv
// Channel for input words of the stepper phase sequencer: op and angle.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sps_cmd_if;
  import sps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output op, output angle, input ready);
  modport sink (input valid, input op, input angle, output ready);
endinterface

`default_nettype wire

FILE: design/sps_res_if.sv
// Channel for result words of the stepper phase sequencer: coils and busy.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sps_res_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coils;
  logic              busy_res;

  modport source (output valid, output coils, output busy_res, input ready);
  modport sink (input valid, input coils, input busy_res, output ready);
endinterface

`default_nettype wire

FILE: design/sps_cfg_if.sv
// Configuration write channel of the stepper phase sequencer.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sps_cfg_if;
  import sps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/stepper_phase_sequencer.sv
// Stepper phase sequencer: four coil lines driven from move and tick words.
// Depends on sps_pkg, sps_cmd_if, sps_res_if and sps_cfg_if.
// Each accepted word yields one result word. One word is accepted per cycle
// unless res.ready stalls. The first stage multiplies the angle magnitude by
// the steps per revolution, the second divides by a reciprocal multiply, the
// third updates the motor state and holds the result. Reset clears the
// pipeline and state, turns the coils off and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module stepper_phase_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  sps_cmd_if.sink   cmd,
  sps_res_if.source res,
  sps_cfg_if.sink   cfg
);
  import sps_pkg::*;

  typedef struct packed {
    logic              op;
    logic              special;
    logic              neg;
    logic [PROD_W-1:0] prod;
  } s1_t;

  typedef struct packed {
    logic               op;
    logic               special;
    logic               neg;
    logic [STEPS_W-1:0] steps;
  } s2_t;

  logic               half_step_mode;
  logic [SPR_W-1:0]   steps_per_rev;
  logic [DELAY_W-1:0] step_delay;

  logic s1_valid, s2_valid, out_valid;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  logic take3, ready2, ready1;

  logic [PHASE_W-1:0] phase_index, phase_index_next;
  logic [STEPS_W-1:0] steps_left, steps_left_next;
  logic               reverse_dir, reverse_dir_next;
  logic               run_forever, run_forever_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;
  logic [COIL_W-1:0]  coil_reg, coil_reg_next;

  logic [MAG_W-1:0]   ang_ext;
  logic [MAG_W-1:0]   mag;
  logic [X_W-1:0]     x_val;
  logic [QPROD_W-1:0] qprod;
  logic [QUOT_W-1:0]  quot;
  logic [DELAY_W-1:0] hold;
  logic [STEPS_W-1:0] steps_dec;
  logic [PHASE_W-1:0] phase_adv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode <= 1'b0;
      steps_per_rev  <= SPR_RESET;
      step_delay     <= DELAY_RESET;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        REG_HALF_STEP_MODE: half_step_mode <= cfg.data[0];
        REG_STEPS_PER_REV:  steps_per_rev  <= cfg.data[SPR_W-1:0];
        REG_STEP_DELAY:     step_delay     <= cfg.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign take3     = !out_valid || res.ready;
  assign ready2    = !s2_valid || take3;
  assign ready1    = !s1_valid || ready2;
  assign cmd.ready = ready1;

  always_comb begin
    ang_ext         = {cmd.angle[ANGLE_W-1], cmd.angle};
    mag             = cmd.angle[ANGLE_W-1] ? (~ang_ext + MAG_W'(1)) : ang_ext;
    s1_next.op      = cmd.op;
    s1_next.special = (32'(cmd.angle) == SPECIAL_ANGLE);
    s1_next.neg     = cmd.angle[ANGLE_W-1];
    s1_next.prod    = PROD_W'(mag) * PROD_W'(steps_per_rev);
  end

  always_comb begin
    x_val           = s1.prod[PROD_W-1:DIV_SH];
    qprod           = QPROD_W'(x_val) * QPROD_W'(RECIP_45);
    quot            = qprod[QPROD_W-1:RECIP_SH];
    s2_next.op      = s1.op;
    s2_next.special = s1.special;
    s2_next.neg     = s1.neg;
    s2_next.steps   = (quot > QUOT_W'(STEPS_MAX)) ? STEPS_MAX : quot[STEPS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ready1) begin
        s1_valid <= cmd.valid;
      end
      if (ready2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1 <= s1_next;
    end
    if (ready2) begin
      s2 <= s2_next;
    end
  end

  always_comb begin
    phase_index_next = phase_index;
    steps_left_next  = steps_left;
    reverse_dir_next = reverse_dir;
    run_forever_next = run_forever;
    delay_count_next = delay_count;
    coil_reg_next    = coil_reg;
    hold             = (step_delay == '0) ? DELAY_W'(1) : step_delay;
    steps_dec        = run_forever ? steps_left : steps_left - STEPS_W'(1);
    phase_adv        = half_step_mode ? phase_index + PHASE_W'(1)
                                      : {1'b0, phase_index[1:0] + 2'd1};
    if (s2.op == OP_MOVE) begin
      phase_index_next = '0;
      delay_count_next = '0;
      if (s2.special) begin
        run_forever_next = 1'b1;
        reverse_dir_next = 1'b0;
        steps_left_next  = '0;
        coil_reg_next    = pattern_at('0, 1'b0, half_step_mode);
      end else begin
        run_forever_next = 1'b0;
        if (s2.steps == '0) begin
          steps_left_next  = '0;
          reverse_dir_next = 1'b0;
          coil_reg_next    = '0;
        end else begin
          steps_left_next  = s2.steps;
          reverse_dir_next = s2.neg;
          coil_reg_next    = pattern_at('0, s2.neg, half_step_mode);
        end
      end
    end else if (run_forever || steps_left != '0) begin
      if ({1'b0, delay_count} + (DELAY_W + 1)'(1) >= {1'b0, hold}) begin
        delay_count_next = '0;
        steps_left_next  = steps_dec;
        if (run_forever || steps_dec != '0) begin
          phase_index_next = phase_adv;
          coil_reg_next    = pattern_at(phase_adv, reverse_dir, half_step_mode);
        end
      end else begin
        delay_count_next = delay_count + DELAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase_index <= '0;
      steps_left  <= '0;
      reverse_dir <= 1'b0;
      run_forever <= 1'b0;
      delay_count <= '0;
      coil_reg    <= '0;
    end else if (take3) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        phase_index <= phase_index_next;
        steps_left  <= steps_left_next;
        reverse_dir <= reverse_dir_next;
        run_forever <= run_forever_next;
        delay_count <= delay_count_next;
        coil_reg    <= coil_reg_next;
      end
    end
  end

  assign res.valid    = out_valid;
  assign res.coils    = coil_reg;
  assign res.busy_res = run_forever || (steps_left != '0);

endmodule

`default_nettype wire

FILE: dv/tb_stepper_phase_sequencer.sv
// Testbench for stepper_phase_sequencer: directed move and tick words, then random
// phases under changing register settings, checked by a local motor model or DRILL.
// Depends on sps_pkg, the three channel interfaces and the design top level.
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer;
  import sps_pkg::*;

  localparam int LIMIT_CYCLES    = 1000000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int ANGLE_PER_REV   = 360 << ANGLE_FRAC_BITS;
  localparam int ENDLESS_ANGLE   = 400 << ANGLE_FRAC_BITS;
  localparam longint STEP_CAP    = 131071;

  localparam logic [3:0] COIL_SEQ [8] = '{
    4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
  };
  localparam logic signed [15:0] EDGE_ANGLES [8] = '{
    16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1, 16'sd6399, 16'sd6401, -16'sd6400
  };

  typedef struct packed {
    logic [3:0] coils;
    logic       busy;
  } coil_word_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] angle;
    logic               typed;
    coil_word_t         want;
  } drill_row_t;

  typedef struct packed {
    logic        half;
    logic [13:0] spr;
    logic [9:0]  dly;
  } reg_set_t;

  localparam drill_row_t DRILL [24] = '{
    '{OP_TICK, 16'sd0,      1'b1, '{4'd0, 1'b0}},
    '{OP_MOVE, 16'sd0,      1'b1, '{4'd0, 1'b0}},
    '{OP_MOVE, 16'sd1,      1'b1, '{4'd0, 1'b0}},
    '{OP_MOVE, -16'sd1,     1'b1, '{4'd0, 1'b0}},
    '{OP_MOVE, 16'sh7fff,   1'b1, '{4'd1, 1'b1}},
    '{OP_MOVE, 16'sh8000,   1'b1, '{4'd8, 1'b1}},
    '{OP_MOVE, 16'sd6400,   1'b1, '{4'd1, 1'b1}},
    '{OP_MOVE, -16'sd6400,  1'b1, '{4'd8, 1'b1}},
    '{OP_MOVE, 16'sd3,      1'b1, '{4'd1, 1'b1}},
    '{OP_TICK, 16'sh7fff,   1'b0, '0},
    '{OP_TICK, 16'sh8000,   1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b1, '{4'd1, 1'b0}},
    '{OP_MOVE, 16'sd6,      1'b0, '0},
    '{OP_MOVE, 16'sd6399,   1'b0, '0},
    '{OP_MOVE, 16'sd6401,   1'b0, '0},
    '{OP_TICK, 16'sd0,      1'b0, '0}
  };

  localparam reg_set_t FIXED_SETS [7] = '{
    '{1'b1, 14'd2048,  10'd1},
    '{1'b0, 14'd1,     10'd1},
    '{1'b1, 14'd8192,  10'd1000},
    '{1'b0, 14'd8192,  10'd2},
    '{1'b1, 14'd200,   10'd0},
    '{1'b0, 14'd16383, 10'd3},
    '{1'b1, 14'd0,     10'd1023}
  };

  logic clk = 1'b0;
  logic rst;

  sps_cmd_if cmd_ch ();
  sps_res_if res_ch ();
  sps_cfg_if cfg_ch ();

  stepper_phase_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies and motor state of the local model.
  logic        c_half;
  logic [13:0] c_spr;
  logic [9:0]  c_delay;
  logic [2:0]  m_phase;
  logic [16:0] m_steps;
  logic        m_rev;
  logic        m_forever;
  logic [9:0]  m_delay_cnt;
  logic [3:0]  m_coils;

  coil_word_t expected_q [$];
  int pace;
  int n_errors, n_results, n_moves, n_endless, n_ticks, n_cfg;
  int cycles;

  function automatic logic [3:0] coil_pattern(logic [2:0] p, logic rev);
    int len, k;
    len = c_half ? 8 : 4;
    k = int'(p) & (len - 1);
    if (rev) begin
      k = len - 1 - k;
    end
    if (!c_half) begin
      k = k * 2;
    end
    return COIL_SEQ[k & 7];
  endfunction

  task automatic step_motor(input op_t op, input logic signed [15:0] ang,
                            output coil_word_t w);
    longint mag, steps;
    int unsigned hold;
    if (op == OP_MOVE) begin
      m_phase = '0;
      m_delay_cnt = '0;
      if (int'(ang) == ENDLESS_ANGLE) begin
        m_forever = 1'b1;
        m_rev = 1'b0;
        m_steps = '0;
        m_coils = coil_pattern(3'd0, 1'b0);
      end else begin
        mag = (ang < 0) ? -longint'(ang) : longint'(ang);
        steps = mag * longint'(c_spr) / longint'(ANGLE_PER_REV);
        if (steps > STEP_CAP) begin
          steps = STEP_CAP;
        end
        m_forever = 1'b0;
        if (steps == 0) begin
          m_steps = '0;
          m_rev = 1'b0;
          m_coils = '0;
        end else begin
          m_steps = steps[16:0];
          m_rev = (ang < 0);
          m_coils = coil_pattern(3'd0, m_rev);
        end
      end
    end else if (m_forever || m_steps != 0) begin
      hold = (c_delay == 0) ? 1 : c_delay;
      if (m_delay_cnt + 1 >= hold) begin
        m_delay_cnt = '0;
        if (!m_forever) begin
          m_steps = m_steps - 1'b1;
        end
        if (m_forever || m_steps != 0) begin
          m_phase = (m_phase + 3'd1) & (c_half ? 3'd7 : 3'd3);
          m_coils = coil_pattern(m_phase, m_rev);
        end
      end else begin
        m_delay_cnt = m_delay_cnt + 10'd1;
      end
    end
    w.coils = m_coils;
    w.busy = m_forever || (m_steps != 0);
  endtask

  function automatic int draw_wait();
    if (pace == 0) begin
      return 0;
    end else if (pace == 1) begin
      return $urandom_range(0, 12);
    end
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic signed [15:0] pick_angle();
    int r, lim, mag;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 16'(ENDLESS_ANGLE);
    end else if (r < 20) begin
      return 16'($urandom);
    end else if (r < 26) begin
      return EDGE_ANGLES[$urandom_range(0, 7)];
    end
    lim = (8 * ANGLE_PER_REV) / ((c_spr == 0) ? 1 : int'(c_spr));
    if (lim > 32767) begin
      lim = 32767;
    end
    if (lim < 1) begin
      lim = 1;
    end
    mag = $urandom_range(0, lim);
    return 16'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  task automatic send_word(input op_t op, input logic signed [15:0] ang,
                           input logic typed, input coil_word_t want);
    int gap;
    coil_word_t w;
    gap = draw_wait();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.op <= op;
    cmd_ch.angle <= ang;
    do @(posedge clk); while (!cmd_ch.ready);
    step_motor(op, ang, w);
    expected_q.insert(expected_q.size(), typed ? want : w);
    if (op == OP_MOVE) begin
      n_moves++;
      if (int'(ang) == ENDLESS_ANGLE) begin
        n_endless++;
      end
    end else begin
      n_ticks++;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [13:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_HALF_STEP_MODE: c_half = data[0];
      REG_STEPS_PER_REV: c_spr = data;
      REG_STEP_DELAY: c_delay = data[9:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_q.size());
      $display("stepper_phase_sequencer test failed");
      $finish;
    end
  end

  // Result side: random stalls, each word checked against the oldest expectation.
  initial begin
    int stall;
    coil_word_t exp_w;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word coils=%h busy=%b", $time, res_ch.coils,
                 res_ch.busy_res);
      end else begin
        exp_w = expected_q.pop_front();
        if (res_ch.coils !== exp_w.coils) begin
          n_errors++;
          $display("%0t: coils expected %h actual %h", $time, exp_w.coils, res_ch.coils);
        end
        if (res_ch.busy_res !== exp_w.busy) begin
          n_errors++;
          $display("%0t: busy expected %b actual %b", $time, exp_w.busy, res_ch.busy_res);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    reg_set_t rs;
    op_t op;
    logic signed [15:0] ang;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_TICK;
    cmd_ch.angle = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_HALF_STEP_MODE;
    cfg_ch.data = '0;
    c_half = 1'b0;
    c_spr = SPR_RESET;
    c_delay = DELAY_RESET;
    m_phase = '0;
    m_steps = '0;
    m_rev = 1'b0;
    m_forever = 1'b0;
    m_delay_cnt = '0;
    m_coils = '0;
    pace = 1;
    n_errors = 0;
    n_results = 0;
    n_moves = 0;
    n_endless = 0;
    n_ticks = 0;
    n_cfg = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DRILL[i]) begin
      send_word(DRILL[i].op, DRILL[i].angle, DRILL[i].typed, DRILL[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      cmd_ch.valid <= 1'b0;
      wait_drained();
      if (ph < 7) begin
        rs = FIXED_SETS[ph];
      end else begin
        rs.half = 1'($urandom_range(0, 1));
        rs.spr = 14'($urandom_range(1, 8192));
        rs.dly = 10'($urandom_range(1, 8));
      end
      write_reg(REG_HALF_STEP_MODE, 14'(rs.half));
      write_reg(REG_STEPS_PER_REV, rs.spr);
      write_reg(REG_STEP_DELAY, 14'(rs.dly));
      cfg_ch.valid <= 1'b0;
      pace = ph % 3;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          op = OP_TICK;
          ang = 16'($urandom);
        end else begin
          op = OP_MOVE;
          ang = pick_angle();
        end
        send_word(op, ang, 1'b0, '0);
      end
    end

    cmd_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d move words (%0d endless starts) and %0d tick words over %0d phases,",
             n_moves, n_endless, n_ticks, PHASES + 1);
    $display("with %0d register writes; %0d result words checked, %0d mismatches.",
             n_cfg, n_results, n_errors);
    if (n_errors == 0) begin
      $display("stepper_phase_sequencer test passed");
    end else begin
      $display("stepper_phase_sequencer test failed");
    end
    $finish;
  end

endmodule
